FILE: design/scfp_pkg.sv
// Shared types and constants for the sum-checked frame parser.
package scfp_pkg;

    localparam logic [7:0] SYNC_RESET = 8'h5A;
    localparam int         DATA_W     = 32;
    localparam int         ADDR_W     = 3;
    localparam int         M_TDATA_W  = 40;

    localparam logic ADDR_SYNC_BYTE = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef struct packed {
        logic        checksum_bad;
        logic [7:0]  payload_len;
        logic [7:0]  frame_type;
        logic [15:0] distance_mm;
    } result_t;

endpackage

FILE: design/scfp_cfg.sv
// APB register file holding the sync byte value.
module scfp_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [scfp_pkg::DATA_W-1:0]  pwdata,
    output logic [scfp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [7:0]                   sync_byte
);

    logic [7:0] sync_reg;
    logic       wr_en;
    logic       sel_sync;

    assign pready   = 1'b1;
    assign sel_sync = (paddr[2] == scfp_pkg::ADDR_SYNC_BYTE);
    assign wr_en    = psel && penable && pwrite && pready && sel_sync;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= scfp_pkg::SYNC_RESET;
        end
        else if (wr_en)
        begin
            sync_reg <= pwdata[7:0];
        end
    end

    assign prdata    = sel_sync ? {24'd0, sync_reg} : '0;
    assign sync_byte = sync_reg;

endmodule

FILE: design/scfp_parser.sv
// Byte-wise frame parsing state machine with running checksum.
module scfp_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    input  logic [7:0]              rx_byte,
    input  logic [7:0]              sync_byte,
    output logic                    result_valid,
    output scfp_pkg::result_t       result
);

    scfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] dist_reg, dist_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_reg, len_next;
    logic        is_sync;

    assign is_sync = (rx_byte == sync_byte);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        dist_next  = dist_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        unique case (phase_reg)
            scfp_pkg::PH_HUNT2:
            begin
                if (is_sync)
                begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = scfp_pkg::PH_TYPE;
                end
                else
                begin
                    phase_next = scfp_pkg::PH_HUNT1;
                    sum_next   = '0;
                    left_next  = '0;
                    idx_next   = '0;
                    dist_next  = '0;
                end
            end
            scfp_pkg::PH_TYPE:
            begin
                type_next  = rx_byte;
                sum_next   = sum_reg + rx_byte;
                phase_next = scfp_pkg::PH_LEN;
            end
            scfp_pkg::PH_LEN:
            begin
                len_next   = rx_byte;
                sum_next   = sum_reg + rx_byte;
                left_next  = rx_byte;
                idx_next   = '0;
                dist_next  = '0;
                phase_next = (rx_byte == 8'd0) ? scfp_pkg::PH_CHECK : scfp_pkg::PH_PAYLOAD;
            end
            scfp_pkg::PH_PAYLOAD:
            begin
                sum_next = sum_reg + rx_byte;
                if (idx_reg == 2'd0)
                begin
                    dist_next = {rx_byte, 8'd0};
                end
                else if (idx_reg == 2'd1)
                begin
                    dist_next = {dist_reg[15:8], rx_byte};
                end
                if (idx_reg != 2'd2)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = scfp_pkg::PH_CHECK;
                end
            end
            scfp_pkg::PH_CHECK:
            begin
                phase_next = scfp_pkg::PH_HUNT1;
                sum_next   = '0;
                left_next  = '0;
                idx_next   = '0;
                dist_next  = '0;
            end
            default:
            begin
                left_next = '0;
                idx_next  = '0;
                dist_next = '0;
                if (is_sync)
                begin
                    sum_next   = rx_byte;
                    phase_next = scfp_pkg::PH_HUNT2;
                end
                else
                begin
                    sum_next   = '0;
                    phase_next = scfp_pkg::PH_HUNT1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scfp_pkg::PH_HUNT1;
            sum_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            dist_reg  <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            dist_reg  <= dist_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        result_valid        = byte_valid && (phase_reg == scfp_pkg::PH_CHECK);
        result.distance_mm  = dist_reg;
        result.frame_type   = type_reg;
        result.payload_len  = len_reg;
        result.checksum_bad = (rx_byte != sum_reg);
    end

endmodule

FILE: design/scfp_out_reg.sv
// Output register that holds one finished result until it is taken.
module scfp_out_reg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  scfp_pkg::result_t                  in_result,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scfp_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic              valid_reg;
    scfp_pkg::result_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg};

endmodule

FILE: design/sum_checked_frame_parser_core.sv
// Top level of the sum-checked frame parser.
//
// Each received byte enters on the slave stream as one word, and the block takes a word in
// every cycle while the output register is empty or being read. Two consecutive sync bytes
// start a frame, followed by type, length, that many payload bytes and an 8-bit wrapping sum
// checksum over all earlier frame bytes. The checksum byte produces one registered result word,
// carrying the big-endian distance from payload bytes 0 and 1 (missing bytes read as
// zero), the type, the length and a checksum failure flag. Hunting for sync resumes right
// after every checksum byte, good or bad. The sync value is the APB register at address 0.
module sum_checked_frame_parser_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] distance_mm, [23:16] frame_type, [31:24] payload_len, [32] checksum_bad
    output logic [scfp_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scfp_pkg::ADDR_W-1:0]       paddr,
    input  logic [scfp_pkg::DATA_W-1:0]       pwdata,
    output logic [scfp_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [7:0]        sync_value;
    logic              byte_valid;
    logic              res_valid;
    scfp_pkg::result_t res;

    assign byte_valid = s_tvalid && s_tready;

    scfp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sync_byte (sync_value)
    );

    scfp_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .rx_byte      (s_tdata),
        .sync_byte    (sync_value),
        .result_valid (res_valid),
        .result       (res)
    );

    scfp_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_result (res),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: design/scfp_checker.sv
// Port-level checker for the sum-checked frame parser, bound to the top level.
module scfp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [scfp_pkg::M_TDATA_W-1:0]    m_tdata
);

    // A held result word stays valid while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A held result word keeps its value while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // The block takes no byte while a finished result cannot leave.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output is blocked");

    // With the output free, the block is always ready for a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Padding bits of a result word are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[scfp_pkg::M_TDATA_W-1:33] == '0))
        else $error("nonzero padding in result word");

endmodule

bind sum_checked_frame_parser_core scfp_checker u_scfp_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the sum-checked frame parser core.
module tb_top;

    typedef logic [7:0] byte_q_t[$];

    localparam int AW          = scfp_pkg::ADDR_W;
    localparam int DW          = scfp_pkg::DATA_W;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam logic [AW-1:0] SYNC_ADDR  = AW'({scfp_pkg::ADDR_SYNC_BYTE, 2'b00});
    localparam logic [AW-1:0] SPARE_ADDR = AW'(4);

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;    // [7:0] rx_byte
    logic                            m_tvalid;
    logic                            m_tready;
    // [15:0] distance_mm, [23:16] frame_type, [31:24] payload_len, [32] checksum_bad
    logic [scfp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [AW-1:0]                   paddr;
    logic [DW-1:0]                   pwdata;
    logic [DW-1:0]                   prdata;
    logic                            pready;

    scfp_pkg::phase_t parse_state = scfp_pkg::PH_HUNT1;
    logic [7:0]  sync_value  = scfp_pkg::SYNC_RESET;
    logic [7:0]  frame_sum   = 8'h00;
    logic [7:0]  remaining   = 8'h00;
    logic [7:0]  pay_idx     = 8'h00;
    logic [15:0] dist_acc    = 16'h0000;
    logic [7:0]  held_kind   = 8'h00;
    logic [7:0]  held_len    = 8'h00;

    scfp_pkg::result_t pending_frames[$];
    int          errors         = 0;
    int          bytes_sent     = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    sum_checked_frame_parser_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, seen, $realtime);
        errors++;
    endtask

    function automatic void restart_hunt();
        parse_state = scfp_pkg::PH_HUNT1;
        frame_sum   = 8'h00;
        remaining   = 8'h00;
        pay_idx     = 8'h00;
        dist_acc    = 16'h0000;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        scfp_pkg::result_t r;
        case (parse_state)
            scfp_pkg::PH_HUNT2:
            begin
                if (b == sync_value)
                begin
                    frame_sum   = frame_sum + b;
                    parse_state = scfp_pkg::PH_TYPE;
                end
                else
                begin
                    restart_hunt();
                end
            end
            scfp_pkg::PH_TYPE:
            begin
                held_kind   = b;
                frame_sum   = frame_sum + b;
                parse_state = scfp_pkg::PH_LEN;
            end
            scfp_pkg::PH_LEN:
            begin
                held_len    = b;
                frame_sum   = frame_sum + b;
                remaining   = b;
                pay_idx     = 8'h00;
                dist_acc    = 16'h0000;
                parse_state = (b == 8'h00) ? scfp_pkg::PH_CHECK : scfp_pkg::PH_PAYLOAD;
            end
            scfp_pkg::PH_PAYLOAD:
            begin
                frame_sum = frame_sum + b;
                if (pay_idx == 8'd0)
                    dist_acc = {b, 8'h00};
                else if (pay_idx == 8'd1)
                    dist_acc = dist_acc | {8'h00, b};
                if (pay_idx != 8'hFF)
                    pay_idx = pay_idx + 8'd1;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    parse_state = scfp_pkg::PH_CHECK;
            end
            scfp_pkg::PH_CHECK:
            begin
                r.distance_mm  = dist_acc;
                r.frame_type   = held_kind;
                r.payload_len  = held_len;
                r.checksum_bad = (b != frame_sum);
                pending_frames.push_back(r);
                restart_hunt();
            end
            default:
            begin
                if (b == sync_value)
                begin
                    frame_sum   = b;
                    parse_state = scfp_pkg::PH_HUNT2;
                end
                else
                begin
                    restart_hunt();
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] kind, input byte_q_t payload,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] len;
        len = 8'(payload.size());
        sum = sync_value + sync_value + kind + len;
        send_byte(sync_value);
        send_byte(sync_value);
        send_byte(kind);
        send_byte(len);
        foreach (payload[i])
        begin
            sum = sum + payload[i];
            send_byte(payload[i]);
        end
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    function automatic byte_q_t random_payload(input int n);
        byte_q_t p;
        for (int i = 0; i < n; i++)
            p.push_back(8'($urandom));
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == SYNC_ADDR)
            sync_value = data[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [AW-1:0] addr, output logic [DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sync(input logic [7:0] value);
        logic [DW-1:0] rd;
        stop_sending();
        wait_drained();
        apb_write(SYNC_ADDR, DW'(value));
        apb_read(SYNC_ADDR, rd);
        if (rd[7:0] !== value)
            report_mismatch("sync_byte readback", 32'(value), 32'(rd));
    endtask

    task automatic test_directed();
        byte_q_t p;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        p.delete();
        send_frame(8'hFF, p, 1'b0);
        p.push_back(8'hFF);
        send_frame(8'h00, p, 1'b1);
        p.delete();
        p.push_back(8'h00);
        p.push_back(8'hFF);
        send_frame(8'h00, p, 1'b0);
        send_byte(sync_value);
        send_byte(8'h12);
        p.delete();
        send_frame(sync_value, p, 1'b0);
    endtask

    task automatic test_register_access();
        logic [DW-1:0] rd;
        set_sync(8'hA5);
        apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
        apb_read(SYNC_ADDR, rd);
        if (rd[7:0] !== 8'hA5)
            report_mismatch("sync_byte after spare write", 32'h0000_00A5, 32'(rd));
        src_idle_pct = 0;
        send_frame(8'h3C, random_payload(3), 1'b0);
        send_frame(8'hC3, random_payload(2), 1'b1);
    endtask

    task automatic test_long_frames();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_frame(8'($urandom), random_payload(255), 1'b0);
        send_frame(8'($urandom), random_payload(255), 1'b1);
    endtask

    task automatic test_random(input int n, input int src_pct, input int sink_pct);
        int start;
        int pick;
        int len;
        start          = bytes_sent;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (bytes_sent - start < n)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) != 0) ? $urandom_range(6) : $urandom_range(7, 40);
            if (pick < 65)
            begin
                send_frame(8'($urandom), random_payload(len), 1'b0);
            end
            else if (pick < 80)
            begin
                send_frame(8'($urandom), random_payload(len), 1'b1);
            end
            else if (pick < 90)
            begin
                send_byte(sync_value);
                send_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(($urandom_range(3) == 0) ? sync_value : 8'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (40)
            send_frame(8'($urandom), random_payload($urandom_range(2)), 1'b0);
    endtask

    task automatic check_result(input logic [scfp_pkg::M_TDATA_W-1:0] word);
        scfp_pkg::result_t got;
        scfp_pkg::result_t want;
        got = word[$bits(scfp_pkg::result_t)-1:0];
        if (pending_frames.size() == 0)
        begin
            report_mismatch("unexpected word", 32'h0, word[31:0]);
        end
        else
        begin
            want = pending_frames.pop_front();
            if (got.distance_mm !== want.distance_mm)
                report_mismatch("distance_mm", 32'(want.distance_mm), 32'(got.distance_mm));
            if (got.frame_type !== want.frame_type)
                report_mismatch("frame_type", 32'(want.frame_type), 32'(got.frame_type));
            if (got.payload_len !== want.payload_len)
                report_mismatch("payload_len", 32'(want.payload_len), 32'(got.payload_len));
            if (got.checksum_bad !== want.checksum_bad)
                report_mismatch("checksum_bad", 32'(want.checksum_bad), 32'(got.checksum_bad));
            if (word[scfp_pkg::M_TDATA_W-1:$bits(scfp_pkg::result_t)] !== '0)
                report_mismatch("padding", 32'h0,
                                32'(word[scfp_pkg::M_TDATA_W-1:$bits(scfp_pkg::result_t)]));
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** sum_checked_frame_parser_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_access();
        test_long_frames();
        set_sync(8'h00);
        test_random(300, 0, 0);
        set_sync(8'hFF);
        test_random(250, 85, 0);
        set_sync(8'($urandom));
        test_random(250, 0, 85);
        set_sync(scfp_pkg::SYNC_RESET);
        test_random(350, 28, 28);
        test_backpressure();
        stop_sending();
        wait_drained();

        if (errors == 0)
            $display("** sum_checked_frame_parser_core: PASSED **");
        else
            $display("** sum_checked_frame_parser_core: FAILED **");
        $finish;
    end

endmodule
